>>> rtl/lcrt_pkg.sv
// shared constants, types and item class codes for the coprime run tracker
package lcrt_pkg;

   // field widths of the request and response transactions
   localparam int VALUE_W      = 32;
   localparam int BEST_LEN_W   = 17;
   localparam int BEST_START_W = 16;

   // defaults for the top level parameters
   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int MAX_ITEMS_DEFAULT  = 65536;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // item classes assigned by the front
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_DATA    = 2'd0;  // needs a gcd run
   localparam kind_type KIND_ONE     = 2'd1;  // value of one, always coprime
   localparam kind_type KIND_RESTART = 2'd2;  // first element of a new sequence
   localparam int KIND_W = 2;

   // status of the gcd unit as seen by the back
   typedef struct packed {
      logic done;
      logic coprime;
   } gcd_status_type;

endpackage

>>> rtl/lcrt_req_if.sv
// request channel: one sequence element per transaction
interface lcrt_req_if;
   logic                       valid;
   logic                       ready;
   logic [lcrt_pkg::VALUE_W-1:0] value;
   logic                       start_of_sequence;

   modport source (output valid, output value, output start_of_sequence, input ready);
   modport sink   (input valid, input value, input start_of_sequence, output ready);
endinterface

>>> rtl/lcrt_rsp_if.sv
// response channel: best run length and start per transaction
interface lcrt_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [lcrt_pkg::BEST_LEN_W-1:0]   best_len;
   logic [lcrt_pkg::BEST_START_W-1:0] best_start;

   modport source (output valid, output best_len, output best_start, input ready);
   modport sink   (input valid, input best_len, input best_start, output ready);
endinterface

>>> rtl/lcrt_front.sv
// front stage: takes request transactions, masks the value and classifies the item
module lcrt_front #(
   parameter int VALUE_BITS = lcrt_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   lcrt_req_if.sink                         req_chan,
   output logic                             push,
   output logic [VALUE_BITS+lcrt_pkg::KIND_W-1:0] push_data,
   input  logic                             full
);

   localparam logic [VALUE_BITS-1:0] ONE = {{(VALUE_BITS-1){1'b0}}, 1'b1};

   logic                      valid_ff, valid_in;
   lcrt_pkg::kind_type        kind_ff, kind_in;
   logic [VALUE_BITS-1:0]     value_ff;
   logic [VALUE_BITS+lcrt_pkg::VALUE_W-1:0] value_ext;
   logic [VALUE_BITS-1:0]     value_masked;
   logic                      take;

   // value reduced modulo 2^VALUE_BITS, zero extended when wider
   assign value_ext    = {{VALUE_BITS{1'b0}}, req_chan.value};
   assign value_masked = value_ext[VALUE_BITS-1:0];

   // no transaction is taken while reset is high
   assign req_chan.ready = !reset && (!valid_ff || !full);
   assign take           = req_chan.valid && req_chan.ready;
   assign push           = valid_ff && !full;
   assign push_data      = {kind_ff, value_ff};

   always_comb begin
      valid_in = valid_ff;
      if (push) valid_in = 1'b0;
      if (take) valid_in = 1'b1;
   end

   always_comb begin
      if (req_chan.start_of_sequence) begin
         kind_in = lcrt_pkg::KIND_RESTART;
      end else if (value_masked == ONE) begin
         kind_in = lcrt_pkg::KIND_ONE;
      end else begin
         kind_in = lcrt_pkg::KIND_DATA;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         kind_ff  <= kind_in;
         value_ff <= value_masked;
      end
   end

endmodule

>>> rtl/lcrt_queue.sv
// small register queue between front and back
module lcrt_queue #(
   parameter int WIDTH = 34,
   parameter int DEPTH = lcrt_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CFULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CFULL);
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (pop)  rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

>>> rtl/lcrt_gcd.sv
// iterative binary gcd unit that decides whether two values are coprime
module lcrt_gcd #(
   parameter int VALUE_BITS = lcrt_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [VALUE_BITS-1:0]   op_a,
   input  logic [VALUE_BITS-1:0]   op_b,
   output lcrt_pkg::gcd_status_type status
);

   localparam logic [VALUE_BITS-1:0] ONE = {{(VALUE_BITS-1){1'b0}}, 1'b1};

   logic                  busy_ff, busy_in;
   logic [VALUE_BITS-1:0] a_ff, a_in;
   logic [VALUE_BITS-1:0] b_ff, b_in;
   logic                  finish;
   logic                  coprime;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      busy_in = busy_ff;
      finish  = 1'b0;
      coprime = 1'b0;
      if (busy_ff) begin
         if (a_ff == '0 || b_ff == '0) begin
            // gcd(x, 0) is x
            finish  = 1'b1;
            coprime = ((a_ff | b_ff) == ONE);
         end else if (a_ff == ONE || b_ff == ONE) begin
            finish  = 1'b1;
            coprime = 1'b1;
         end else if (a_ff == b_ff || (!a_ff[0] && !b_ff[0])) begin
            finish = 1'b1;
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ff > b_ff) begin
            a_in = a_ff - b_ff;
         end else begin
            b_in = b_ff - a_ff;
         end
         if (finish) busy_in = 1'b0;
      end
      if (start) begin
         a_in    = op_a;
         b_in    = op_b;
         busy_in = 1'b1;
      end
   end

   assign status.done    = finish;
   assign status.coprime = coprime;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
   end

endmodule

>>> rtl/lcrt_back.sv
// back stage: runs the coprime test, updates the run tracker and holds the response
module lcrt_back #(
   parameter int VALUE_BITS = lcrt_pkg::VALUE_BITS_DEFAULT,
   parameter int MAX_ITEMS  = lcrt_pkg::MAX_ITEMS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   empty,
   input  logic [VALUE_BITS+lcrt_pkg::KIND_W-1:0] pop_data,
   output logic                                   pop,
   output logic                                   gcd_start,
   output logic [VALUE_BITS-1:0]                  gcd_a,
   output logic [VALUE_BITS-1:0]                  gcd_b,
   input  lcrt_pkg::gcd_status_type               gcd_status,
   lcrt_rsp_if.source                             rsp_chan
);

   localparam int IDX_W = $clog2(MAX_ITEMS);
   localparam int LEN_W = $clog2(MAX_ITEMS + 1);
   localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_ITEMS - 1);
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_ITEMS);
   localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_GCD  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0]            state_ff, state_in;
   lcrt_pkg::kind_type    kind_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic                  cop_ff, cop_in;

   logic [VALUE_BITS-1:0] prev_ff, prev_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [LEN_W-1:0]      run_len_ff, run_len_in;
   logic [IDX_W-1:0]      run_start_ff, run_start_in;
   logic [LEN_W-1:0]      long_len_ff, long_len_in;
   logic [IDX_W-1:0]      long_start_ff, long_start_in;

   logic                  out_valid_ff, out_valid_in;
   logic [LEN_W-1:0]      out_len_ff;
   logic [IDX_W-1:0]      out_start_ff;
   logic [LEN_W+lcrt_pkg::BEST_LEN_W-1:0]   len_ext;
   logic [IDX_W+lcrt_pkg::BEST_START_W-1:0] start_ext;

   lcrt_pkg::kind_type    pop_kind;
   logic                  commit;

   assign pop_kind  = pop_data[VALUE_BITS +: lcrt_pkg::KIND_W];
   assign pop       = (state_ff == ST_IDLE) && !empty;
   assign gcd_start = pop && (pop_kind == lcrt_pkg::KIND_DATA);
   assign gcd_a     = pop_data[VALUE_BITS-1:0];
   assign gcd_b     = prev_ff;
   assign commit    = (state_ff == ST_FIN) && (!out_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in = state_ff;
      cop_in   = cop_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               cop_in   = (pop_kind == lcrt_pkg::KIND_ONE);
               state_in = (pop_kind == lcrt_pkg::KIND_DATA) ? ST_GCD : ST_FIN;
            end
         end
         ST_GCD: begin
            if (gcd_status.done) begin
               cop_in   = gcd_status.coprime;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (commit) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // tracker update for the item in hand
   always_comb begin
      prev_in       = value_ff;
      idx_in        = idx_ff;
      run_len_in    = run_len_ff;
      run_start_in  = run_start_ff;
      long_len_in   = long_len_ff;
      long_start_in = long_start_ff;
      if (kind_ff == lcrt_pkg::KIND_RESTART) begin
         idx_in        = '0;
         run_len_in    = LEN_ONE;
         run_start_in  = '0;
         long_len_in   = LEN_ONE;
         long_start_in = '0;
      end else begin
         if (idx_ff < MAX_IDX) idx_in = idx_ff + IDX_W'(1);
         if (cop_ff) begin
            if (run_len_ff < MAX_LEN) run_len_in = run_len_ff + LEN_ONE;
            if (run_len_in > long_len_ff) begin
               long_len_in   = run_len_in;
               long_start_in = run_start_ff;
            end
         end else begin
            run_len_in   = LEN_ONE;
            run_start_in = idx_in;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_chan.ready) out_valid_in = 1'b0;
      if (commit)         out_valid_in = 1'b1;
   end

   assign len_ext             = {{lcrt_pkg::BEST_LEN_W{1'b0}}, out_len_ff};
   assign start_ext           = {{lcrt_pkg::BEST_START_W{1'b0}}, out_start_ff};
   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.best_len   = len_ext[lcrt_pkg::BEST_LEN_W-1:0];
   assign rsp_chan.best_start = start_ext[lcrt_pkg::BEST_START_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         out_valid_ff  <= 1'b0;
         prev_ff       <= '0;
         idx_ff        <= '0;
         run_len_ff    <= LEN_ONE;
         run_start_ff  <= '0;
         long_len_ff   <= LEN_ONE;
         long_start_ff <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         if (commit) begin
            prev_ff       <= prev_in;
            idx_ff        <= idx_in;
            run_len_ff    <= run_len_in;
            run_start_ff  <= run_start_in;
            long_len_ff   <= long_len_in;
            long_start_ff <= long_start_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      cop_ff <= cop_in;
      if (pop) begin
         kind_ff  <= pop_kind;
         value_ff <= pop_data[VALUE_BITS-1:0];
      end
      if (commit) begin
         out_len_ff   <= long_len_in;
         out_start_ff <= long_start_in;
      end
   end

endmodule

>>> rtl/longest_coprime_run_tracker.sv
// top level: longest run of coprime neighbors, one response per request transaction
// path: front request register, then the queue, then the back and its response register;
//    restart items and values of one skip the binary gcd steps that all other items take
// flow: the back handles one item at a time and its gcd loop sets the pace; front and
//    queue keep taking requests meanwhile until the queue and the front register are full
// reset: synchronous, active high; tracker returns to length one at index zero
module longest_coprime_run_tracker #(
   parameter int VALUE_BITS = lcrt_pkg::VALUE_BITS_DEFAULT,
   parameter int MAX_ITEMS  = lcrt_pkg::MAX_ITEMS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   lcrt_req_if.sink    req_chan,
   lcrt_rsp_if.source  rsp_chan
);

   // queue entry carries the item class above the masked value
   localparam int ENTRY_W = VALUE_BITS + lcrt_pkg::KIND_W;

   // front to queue
   logic               q_push;
   logic [ENTRY_W-1:0] q_push_data;
   logic               q_full;

   // queue to back
   logic               q_pop;
   logic [ENTRY_W-1:0] q_pop_data;
   logic               q_empty;

   // back to gcd unit and its status
   logic                     gcd_start;
   logic [VALUE_BITS-1:0]    gcd_a;
   logic [VALUE_BITS-1:0]    gcd_b;
   lcrt_pkg::gcd_status_type gcd_status;

   // front: request transaction register and classification
   lcrt_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full)
   );

   // queue decouples the front from the gcd loop
   lcrt_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (lcrt_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   // shift-subtract gcd, one step a cycle
   lcrt_gcd #(
      .VALUE_BITS (VALUE_BITS)
   ) u_gcd (
      .clock  (clock),
      .reset  (reset),
      .start  (gcd_start),
      .op_a   (gcd_a),
      .op_b   (gcd_b),
      .status (gcd_status)
   );

   // back: sequencer, run tracker and response register
   lcrt_back #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_ITEMS  (MAX_ITEMS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (q_empty),
      .pop_data   (q_pop_data),
      .pop        (q_pop),
      .gcd_start  (gcd_start),
      .gcd_a      (gcd_a),
      .gcd_b      (gcd_b),
      .gcd_status (gcd_status),
      .rsp_chan   (rsp_chan)
   );

`ifndef SYNTHESIS
   // the front never writes into a full queue
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full) else $error("push into full queue");

   // the back never takes from an empty queue
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty) else $error("pop from empty queue");

   // a gcd finishing never overlaps the back fetching the next item
   a_done_not_with_pop: assert property (@(posedge clock) disable iff (reset)
      gcd_status.done |-> !q_pop) else $error("gcd done while back fetches");

   // a new gcd run starts only from an idle unit, never on the cycle after a start
   a_start_spacing: assert property (@(posedge clock) disable iff (reset)
      gcd_start |=> !gcd_start) else $error("back-to-back gcd start");
`endif

endmodule

>>> tb/sv/tb_longest_coprime_run_tracker.sv
// testbench for the longest coprime run tracker: directed, random and long run tests
`timescale 1ns / 1ps

module tb_longest_coprime_run_tracker;

   // clock period is 20 ns, reset length in clock cycles
   localparam int RESET_CYCLES = 9;

   // predictor copy of the block parameters, same as the defaults the uut uses
   localparam int VALUE_BITS = lcrt_pkg::VALUE_BITS_DEFAULT;
   localparam int MAX_ITEMS  = lcrt_pkg::MAX_ITEMS_DEFAULT;

   // local copies of the field widths
   localparam int VAL_W   = lcrt_pkg::VALUE_W;
   localparam int LEN_W   = lcrt_pkg::BEST_LEN_W;
   localparam int START_W = lcrt_pkg::BEST_START_W;

   // random part size and the length of the one long receiver hold-off
   localparam int RANDOM_ITEMS    = 800;
   localparam int HOLD_OFF_CYCLES = 400;

   // values of one past the start item in the long run test
   localparam int LONG_RUN_ITEMS = 150;

   // settle time after the last response: a full gcd loop plus the front and back overhead
   localparam int DRAIN_CYCLES = 2 * VALUE_BITS + 16;

   // timeout: about 1100 items, each at the worst gcd time plus the longest sender gap and
   // receiver stall, and the hold-off, then taken over ten times
   localparam longint LIMIT_CYCLES = 2_000_000;

   // receiver behavior
   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_PATTERN,
      RX_RANDOM
   } rx_mode_type;

   // what one response transaction should carry
   typedef struct packed {
      logic [LEN_W-1:0]   best_len;
      logic [START_W-1:0] best_start;
   } best_run_type;

   logic clock = 1'b0;
   logic reset;

   lcrt_req_if req_chan ();
   lcrt_rsp_if rsp_chan ();

   longest_coprime_run_tracker uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // run tracker predictor, its own copy of the block state
   // ---------------------------------------------------------------------------------------
   logic [VAL_W-1:0]   last_value;
   logic [START_W-1:0] elem_index;
   logic [LEN_W-1:0]   cur_run_len;
   logic [START_W-1:0] cur_run_start;
   logic [LEN_W-1:0]   top_run_len;
   logic [START_W-1:0] top_run_start;

   // best run expected from each accepted request, oldest first
   best_run_type expected_best_runs[$];

   // euclid on the raw values, gcd(x, 0) = x so a zero pairs only with one
   function automatic bit coprime_pair(input logic [VAL_W-1:0] a,
                                       input logic [VAL_W-1:0] b);
      logic [VAL_W-1:0] x;
      logic [VAL_W-1:0] y;
      logic [VAL_W-1:0] r;
      x = a;
      y = b;
      while (y != '0) begin
         r = x % y;
         x = y;
         y = r;
      end
      return x == 1;
   endfunction

   task automatic clear_run_tracker();
      last_value    = '0;
      elem_index    = '0;
      cur_run_len   = LEN_W'(1);
      cur_run_start = '0;
      top_run_len   = LEN_W'(1);
      top_run_start = '0;
   endtask

   // advance the predicted state by one element and queue the best run it leaves
   task automatic track_element(input logic [VAL_W-1:0] v, input logic first);
      best_run_type best;
      if (first) begin
         // element 0 of a new sequence: everything reloads
         elem_index    = '0;
         cur_run_len   = LEN_W'(1);
         cur_run_start = '0;
         top_run_len   = LEN_W'(1);
         top_run_start = '0;
      end else begin
         // index sticks at the top instead of wrapping
         if (elem_index < MAX_ITEMS - 1) elem_index = elem_index + 1'b1;
         if (coprime_pair(v, last_value)) begin
            if (cur_run_len < MAX_ITEMS) cur_run_len = cur_run_len + 1'b1;
            // strictly longer only, a tie keeps the earlier run
            if (cur_run_len > top_run_len) begin
               top_run_len   = cur_run_len;
               top_run_start = cur_run_start;
            end
         end else begin
            cur_run_len   = LEN_W'(1);
            cur_run_start = elem_index;
         end
      end
      last_value      = v;
      best.best_len   = top_run_len;
      best.best_start = top_run_start;
      expected_best_runs.push_back(best);
   endtask

   // ---------------------------------------------------------------------------------------
   // bookkeeping
   // ---------------------------------------------------------------------------------------
   int     fail_count;
   int     requests_sent;
   int     responses_checked;
   int     restarts_sent;
   longint cycle_count;
   logic [LEN_W-1:0] longest_len_seen;

   // ---------------------------------------------------------------------------------------
   // sender: bursts of random length with random gaps, gaps can be switched off
   // ---------------------------------------------------------------------------------------
   bit sender_gaps;
   int burst_left;

   // offer one element and wait for its transaction, the gap (if any) comes before it
   task automatic send_element(input logic [VAL_W-1:0] v, input logic first);
      if (sender_gaps && burst_left == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end else if (burst_left > 0) begin
         burst_left--;
      end
      req_chan.valid             <= 1'b1;
      req_chan.value             <= v;
      req_chan.start_of_sequence <= first;
      do @(posedge clock); while (!req_chan.ready);
      // accepted at this edge
      track_element(v, first);
      requests_sent++;
      if (first) restarts_sent++;
   endtask

   // drop valid and wait until every expected response has come back
   task automatic wait_all_responses();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (expected_best_runs.size() != 0);
   endtask

   // next element of a random sequence, weighted toward coprime neighbors and clean breaks
   function automatic logic [VAL_W-1:0] pick_element(input logic [VAL_W-1:0] prev);
      logic [VAL_W-1:0] v;
      case ($urandom_range(0, 13))
         0:       v = 1;
         1:       v = '0;
         2, 3:    v = $urandom;
         4, 5, 6: v = prev + 1'b1;                           // coprime with prev unless prev + 1 wraps to zero
         7:       v = prev * $urandom_range(2, 9);           // usually shares a factor
         8, 9:    v = $urandom_range(2, 60);
         10:      v = 1 << $urandom_range(0, VAL_W - 1);
         11:      v = '1 - $urandom_range(0, 8);
         12:      v = prev;                                  // breaks the run unless one
         default: v = $urandom | 1;
      endcase
      return v;
   endfunction

   // ---------------------------------------------------------------------------------------
   // receiver: stall patterns plus an on-demand long hold-off counted here
   // ---------------------------------------------------------------------------------------
   rx_mode_type rx_mode;
   int          hold_off_requests;   // written by the tests only
   int          hold_off_served;     // written by the receiver only
   int          hold_off_left;
   int          rx_stall_left;
   int          rx_phase;

   initial begin
      rsp_chan.ready    <= 1'b0;
      hold_off_served   = 0;
      hold_off_left     = 0;
      rx_stall_left     = 0;
      rx_phase          = 0;
      forever begin
         @(posedge clock);
         rx_phase++;
         if (hold_off_served != hold_off_requests) begin
            hold_off_served++;
            hold_off_left = HOLD_OFF_CYCLES;
         end
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_ALWAYS: begin
                  rsp_chan.ready <= 1'b1;
               end
               RX_PATTERN: begin
                  // fixed rhythm of short stalls
                  rsp_chan.ready <= ((rx_phase % 13) < 9) && ((rx_phase % 5) != 2);
               end
               default: begin
                  if (rx_stall_left > 0) begin
                     rx_stall_left--;
                     rsp_chan.ready <= 1'b0;
                  end else if ($urandom_range(0, 31) == 0) begin
                     rx_stall_left = $urandom_range(1, 20);
                     rsp_chan.ready <= 1'b0;
                  end else begin
                     rsp_chan.ready <= ($urandom_range(0, 3) != 0);
                  end
               end
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // response checker
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      best_run_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_best_runs.size() == 0) begin
            $error("unexpected response: best_len %0d best_start %0d",
                   rsp_chan.best_len, rsp_chan.best_start);
            fail_count++;
         end else begin
            want = expected_best_runs.pop_front();
            if (rsp_chan.best_len !== want.best_len) begin
               $error("best_len mismatch: expected %0d, actual %0d",
                      want.best_len, rsp_chan.best_len);
               fail_count++;
            end
            if (rsp_chan.best_start !== want.best_start) begin
               $error("best_start mismatch: expected %0d, actual %0d",
                      want.best_start, rsp_chan.best_start);
               fail_count++;
            end
            if (want.best_len > longest_len_seen) longest_len_seen = want.best_len;
            responses_checked++;
         end
      end
   end

   // timeout
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------------------

   // reset state acts as element 0 of value 0, only a one is coprime with it
   task automatic test_items_before_first_start();
      rx_mode <= RX_PATTERN;
      send_element(1, 1'b0);
      send_element(1, 1'b0);
      send_element(0, 1'b0);
      send_element(0, 1'b0);            // gcd(0, 0) = 0, run breaks
      send_element(5, 1'b0);
      wait_all_responses();
   endtask

   // extremes of the value field and zero operands
   task automatic test_operand_extremes();
      rx_mode <= RX_ALWAYS;
      send_element('1, 1'b1);
      send_element(32'hFFFF_FFFE, 1'b0);
      send_element(0, 1'b0);            // zero against an even value
      send_element(0, 1'b0);
      send_element(1, 1'b0);
      send_element(32'h8000_0000, 1'b0);
      send_element(32'h8000_0000, 1'b0);
      send_element(32'hFFFF_FFFB, 1'b0); // largest 32 bit prime
      send_element(32'hFFFF_FFFB, 1'b0);
      wait_all_responses();
   endtask

   // a later run of equal length must not replace the first one
   task automatic test_equal_length_tie();
      rx_mode <= RX_RANDOM;
      send_element(2, 1'b1);
      send_element(3, 1'b0);
      send_element(9, 1'b0);
      send_element(10, 1'b0);           // ties the first run
      send_element(11, 1'b0);           // now strictly longer
      wait_all_responses();
   endtask

   // back to back and mid-sequence restarts
   task automatic test_sequence_restarts();
      rx_mode <= RX_PATTERN;
      send_element(6, 1'b1);
      send_element(6, 1'b1);
      send_element(35, 1'b0);
      send_element(1, 1'b1);
      send_element(1, 1'b0);
      wait_all_responses();
   endtask

   // receiver holds off for a long stretch while the sender keeps offering
   task automatic test_input_backpressure();
      logic [VAL_W-1:0] v;
      rx_mode           <= RX_ALWAYS;
      hold_off_requests <= hold_off_requests + 1;
      sender_gaps = 1'b0;
      v = $urandom;
      send_element(v, 1'b1);
      repeat (39) begin
         v = pick_element(v);
         send_element(v, 1'b0);
      end
      wait_all_responses();
      sender_gaps = 1'b1;
   endtask

   // mostly well formed sequences with random content, some noise between them
   task automatic test_random_sequences();
      logic [VAL_W-1:0] v;
      int               sent;
      int               seq_len;
      sent = 0;
      v    = '0;
      while (sent < RANDOM_ITEMS) begin
         // new receiver behavior now and then
         if ($urandom_range(0, 3) == 0) rx_mode <= rx_mode_type'($urandom_range(0, 2));
         if ($urandom_range(0, 19) < 17) begin
            seq_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90)
                                                  : $urandom_range(1, 30);
            v = pick_element(v);
            send_element(v, 1'b1);
            sent++;
            repeat (seq_len) begin
               v = pick_element(v);
               send_element(v, 1'b0);
               sent++;
            end
         end else begin
            // noise: stray restarts or loose elements tacked onto the last sequence
            repeat ($urandom_range(1, 4)) begin
               v = $urandom;
               send_element(v, 1'($urandom_range(0, 1)));
               sent++;
            end
         end
      end
      wait_all_responses();
   endtask

   // a long run of ones with no gaps, then breaks and short runs after it
   task automatic test_long_coprime_run();
      rx_mode <= RX_ALWAYS;
      sender_gaps = 1'b0;
      send_element(1, 1'b1);
      repeat (LONG_RUN_ITEMS) send_element(1, 1'b0);
      // breaks and short runs behind the long one
      send_element(2, 1'b0);
      send_element(4, 1'b0);
      send_element(3, 1'b0);
      send_element(9, 1'b0);
      send_element(1, 1'b0);
      send_element(7, 1'b1);
      send_element(8, 1'b0);
      wait_all_responses();
      sender_gaps = 1'b1;
   endtask

   initial begin
      reset                      <= 1'b1;
      req_chan.valid             <= 1'b0;
      req_chan.value             <= '0;
      req_chan.start_of_sequence <= 1'b0;
      rx_mode                    <= RX_ALWAYS;
      hold_off_requests          <= 0;
      fail_count        = 0;
      requests_sent     = 0;
      responses_checked = 0;
      restarts_sent     = 0;
      cycle_count       = 0;
      longest_len_seen  = '0;
      sender_gaps       = 1'b1;
      burst_left        = 0;
      clear_run_tracker();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_items_before_first_start();
      test_operand_extremes();
      test_equal_length_tie();
      test_sequence_restarts();
      test_input_backpressure();
      test_random_sequences();
      test_long_coprime_run();

      // anything still in flight shows up as an unexpected response
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d request transactions (%0d restarts), %0d responses checked",
               requests_sent, restarts_sent, responses_checked);
      $display("longest run reported %0d, with a long hold-off and a long run of ones",
               longest_len_seen);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
